@@ rtl/chfm_pkg.sv @@
// Shared constants, arctangent table and pipeline payload type for the compass heading block.
package chfm_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int ATAN_TABLE_LEN = 24;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W = 8;
    localparam int PRESCALE = 8;
    localparam int CORDIC_W = SAMPLE_W + PRESCALE + 3;
    localparam int ANGLE_W = 32;
    localparam int DEG_W = 9;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_X_GAIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECLINATION = 2'd2;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic [ANGLE_W-1:0] ATAN_UNITS [ATAN_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                       hold;
        logic signed [CORDIC_W-1:0] re;
        logic signed [CORDIC_W-1:0] im;
        logic [ANGLE_W-1:0]         ang;
    } chfm_vec_t;

endpackage

@@ rtl/compass_heading_from_magnetometer.sv @@
// Compass heading from a magnetometer X/Y pair: calibration, CORDIC atan2, declination, degrees.
// Throughput is one transaction per cycle; busy stays low, since the receiver cannot stall.
// The pipeline is three entry stages, one stage per CORDIC micro-rotation and one output stage.
// Reset clears all valid bits and loads the registers with gain 2, offset -2000, declination -858.
// No result is lost or repeated across reset release; in-flight transactions are dropped by reset.
module compass_heading_from_magnetometer
    import chfm_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] mag_x_raw,
    input  logic signed [SAMPLE_W-1:0] mag_y_raw,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output logic                       done,
    output logic [DEG_W-1:0]           azimuth_deg
);

    // The declination in binary angle units is round(|d| * 2^32 / 36000), split as
    // |d| * 119304 + floor((|d| * 728 + 562) / 1125), the last by a reciprocal multiply.
    localparam int DEC_WHOLE_MUL = 119304;
    localparam int DEC_FRAC_MUL = 728;
    localparam int DEC_FRAC_ADD = 562;
    localparam int FRAC_W = 25;
    localparam int RECIP_W = 26;
    localparam logic [RECIP_W-1:0] DEC_RECIP = 26'd61083980;
    localparam int DEC_RECIP_SHIFT = 36;
    localparam int RECIP_PROD_W = FRAC_W + RECIP_W;
    localparam int QUOT_W = RECIP_PROD_W - DEC_RECIP_SHIFT;
    localparam int PROD_W = SAMPLE_W + GAIN_W;
    localparam int DEG_PROD_W = ANGLE_W + DEG_W;
    localparam logic [DEG_W-1:0] FULL_CIRCLE_DEG = 9'd360;

    logic signed [GAIN_W-1:0]   x_gain_reg;
    logic [SAMPLE_W-1:0]        x_offset_reg;
    logic [SAMPLE_W-1:0]        declination_reg;

    logic                       a_valid_reg;
    logic signed [PROD_W-1:0]   a_prod_reg;
    logic signed [SAMPLE_W-1:0] a_y_reg;
    logic [SAMPLE_W-1:0]        a_off_reg;
    logic [FRAC_W-1:0]          a_frac_reg;
    logic [ANGLE_W-1:0]         a_whole_reg;
    logic                       a_dneg_reg;
    logic signed [PROD_W-1:0]   a_prod_next;
    logic [SAMPLE_W-1:0]        decl_mag;
    logic [FRAC_W-1:0]          a_frac_next;
    logic [ANGLE_W-1:0]         a_whole_next;

    logic                       b_valid_reg;
    logic signed [SAMPLE_W-1:0] b_xc_reg;
    logic signed [SAMPLE_W-1:0] b_y_reg;
    logic [QUOT_W-1:0]          b_quot_reg;
    logic [ANGLE_W-1:0]         b_whole_reg;
    logic                       b_dneg_reg;
    logic [SAMPLE_W-1:0]        b_xc_next;
    logic [RECIP_PROD_W-1:0]    b_recip_prod;

    logic                       c_valid_reg;
    chfm_vec_t                  c_vec_reg;
    chfm_vec_t                  c_vec_next;
    logic [ANGLE_W-1:0]         c_dec;
    logic [ANGLE_W-1:0]         c_base;
    logic                       c_y_zero;
    logic                       c_y_neg;
    logic signed [CORDIC_W-1:0] c_re_raw;
    logic signed [CORDIC_W-1:0] c_im_raw;

    logic                       cordic_valid;
    chfm_vec_t                  cordic_vec;
    logic [DEG_PROD_W-1:0]      deg_prod;
    logic                       done_reg;
    logic [DEG_W-1:0]           azimuth_deg_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_gain_reg <= 8'sd2;
            x_offset_reg <= 16'hF830;
            declination_reg <= 16'hFCA6;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_X_GAIN:      x_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_X_OFFSET:    x_offset_reg <= cfg_data;
                REG_DECLINATION: declination_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign a_prod_next = PROD_W'(x_gain_reg) * PROD_W'(mag_x_raw);
    assign decl_mag = declination_reg[SAMPLE_W-1] ? (~declination_reg + 16'd1)
                                                  : declination_reg;
    assign a_frac_next = FRAC_W'(decl_mag) * FRAC_W'(DEC_FRAC_MUL) + FRAC_W'(DEC_FRAC_ADD);
    assign a_whole_next = ANGLE_W'(decl_mag) * ANGLE_W'(DEC_WHOLE_MUL);

    assign b_xc_next = a_prod_reg[SAMPLE_W-1:0] + a_off_reg;
    assign b_recip_prod = RECIP_PROD_W'(a_frac_reg) * RECIP_PROD_W'(DEC_RECIP);

    assign c_dec = b_whole_reg + ANGLE_W'(b_quot_reg);
    assign c_y_zero = (b_y_reg == '0);
    assign c_y_neg = b_y_reg[SAMPLE_W-1];
    assign c_base = (c_y_zero ? b_xc_reg[SAMPLE_W-1] : c_y_neg) ? HALF_TURN : '0;
    assign c_re_raw = CORDIC_W'(b_y_reg) <<< PRESCALE;
    assign c_im_raw = CORDIC_W'(b_xc_reg) <<< PRESCALE;

    always_comb
    begin
        c_vec_next.hold = c_y_zero;
        c_vec_next.re = c_y_neg ? -c_re_raw : c_re_raw;
        c_vec_next.im = c_y_neg ? -c_im_raw : c_im_raw;
        c_vec_next.ang = b_dneg_reg ? (c_base + c_dec) : (c_base - c_dec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            done_reg <= cordic_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_prod_reg <= a_prod_next;
        a_y_reg <= mag_y_raw;
        a_off_reg <= x_offset_reg;
        a_frac_reg <= a_frac_next;
        a_whole_reg <= a_whole_next;
        a_dneg_reg <= declination_reg[SAMPLE_W-1];

        b_xc_reg <= b_xc_next;
        b_y_reg <= a_y_reg;
        b_quot_reg <= b_recip_prod[RECIP_PROD_W-1:DEC_RECIP_SHIFT];
        b_whole_reg <= a_whole_reg;
        b_dneg_reg <= a_dneg_reg;

        c_vec_reg <= c_vec_next;

        azimuth_deg_reg <= deg_prod[DEG_PROD_W-1:ANGLE_W];
    end

    chfm_cordic #(
        .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c_valid_reg),
        .in_vec   (c_vec_reg),
        .out_valid(cordic_valid),
        .out_vec  (cordic_vec)
    );

    assign deg_prod = DEG_PROD_W'(cordic_vec.ang) * DEG_PROD_W'(FULL_CIRCLE_DEG);

    assign done = done_reg;
    assign azimuth_deg = azimuth_deg_reg;

endmodule

@@ rtl/chfm_cordic.sv @@
// Unrolled vectoring CORDIC pipeline, one micro-rotation per register stage.
module chfm_cordic
    import chfm_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  chfm_vec_t in_vec,
    output logic      out_valid,
    output chfm_vec_t out_vec
);

    logic      stage_valid_reg [ANGLE_ITERATIONS];
    chfm_vec_t stage_vec_reg [ANGLE_ITERATIONS];

    genvar i;
    generate
        for (i = 0; i < ANGLE_ITERATIONS; i++)
        begin : g_stage
            logic                       src_valid;
            chfm_vec_t                  src_vec;
            chfm_vec_t                  stage_vec_next;
            logic signed [CORDIC_W-1:0] src_re;
            logic signed [CORDIC_W-1:0] src_im;
            logic signed [CORDIC_W-1:0] shift_re;
            logic signed [CORDIC_W-1:0] shift_im;

            if (i == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_vec = in_vec;
            end
            else
            begin : g_rest
                assign src_valid = stage_valid_reg[i-1];
                assign src_vec = stage_vec_reg[i-1];
            end

            assign src_re = src_vec.re;
            assign src_im = src_vec.im;
            assign shift_re = src_re >>> i;
            assign shift_im = src_im >>> i;

            always_comb
            begin
                stage_vec_next = src_vec;
                if (!src_vec.hold)
                begin
                    if (src_im > 0)
                    begin
                        stage_vec_next.re = src_re + shift_im;
                        stage_vec_next.im = src_im - shift_re;
                        stage_vec_next.ang = src_vec.ang + ATAN_UNITS[i];
                    end
                    else
                    begin
                        stage_vec_next.re = src_re - shift_im;
                        stage_vec_next.im = src_im + shift_re;
                        stage_vec_next.ang = src_vec.ang - ATAN_UNITS[i];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_valid_reg[i] <= 1'b0;
                end
                else
                begin
                    stage_valid_reg[i] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                stage_vec_reg[i] <= stage_vec_next;
            end
        end
    endgenerate

    assign out_valid = stage_valid_reg[ANGLE_ITERATIONS-1];
    assign out_vec = stage_vec_reg[ANGLE_ITERATIONS-1];

endmodule

@@ sim/tb.sv @@
// Testbench for the compass heading block: directed and random sample pairs checked against an in-bench heading predictor.
module tb;
    import chfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = ANGLE_ITERATIONS_DEF + 4;
    localparam int NUM_SETTINGS = 8;
    localparam int RANDOM_PER_SETTING = 160;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [SAMPLE_W-1:0] CORNERS [4] = '{
        16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF
    };

    typedef struct {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
    } sample_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [SAMPLE_W-1:0] mag_x_raw = '0;
    logic signed [SAMPLE_W-1:0] mag_y_raw = '0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       done;
    logic [DEG_W-1:0]           azimuth_deg;

    logic signed [GAIN_W-1:0]   gain_reg = 8'sd2;
    logic signed [SAMPLE_W-1:0] offset_reg = -16'sd2000;
    logic signed [SAMPLE_W-1:0] decl_reg = -16'sd858;

    sample_t          pending [$];
    logic [DEG_W-1:0] heading_q [$];
    logic [DEG_W-1:0] want;
    sample_t          cur;
    int               burst_left = 1;
    int               gap_left = 0;
    int               sent = 0;
    int               checked = 0;
    int               errors = 0;

    compass_heading_from_magnetometer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mag_x_raw  (mag_x_raw),
        .mag_y_raw  (mag_y_raw),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .azimuth_deg(azimuth_deg)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200_000;
        $display("tb: failure");
        $finish;
    end

    // Calibrate X, take atan2 by micro-rotations in binary angle units, remove declination, scale to degrees.
    function automatic logic [DEG_W-1:0] heading_of(logic signed [SAMPLE_W-1:0] xr,
                                                    logic signed [SAMPLE_W-1:0] yr);
        longint                     prod;
        logic signed [SAMPLE_W-1:0] xc;
        longint                     re;
        longint                     im;
        longint                     dr;
        longint                     di;
        logic [ANGLE_W-1:0]         ang;
        logic [ANGLE_W-1:0]         dec_units;
        logic [ANGLE_W-1:0]         bearing;
        logic [63:0]                mag;
        logic [63:0]                q;
        logic [63:0]                scaled;
        prod = longint'(gain_reg) * longint'(xr) + longint'(offset_reg);
        xc = prod[SAMPLE_W-1:0];
        if (yr == 0) begin
            ang = (xc < 0) ? HALF_TURN : '0;
        end else begin
            re = longint'(yr) * 256;
            im = longint'(xc) * 256;
            ang = '0;
            if (re < 0) begin
                re = -re;
                im = -im;
                ang = HALF_TURN;
            end
            for (int i = 0; i < ANGLE_ITERATIONS_DEF; i++) begin
                dr = im >>> i;
                di = re >>> i;
                if (im > 0) begin
                    re = re + dr;
                    im = im - di;
                    ang = ang + ATAN_UNITS[i];
                end else begin
                    re = re - dr;
                    im = im + di;
                    ang = ang - ATAN_UNITS[i];
                end
            end
        end
        mag = (decl_reg < 0) ? 64'(-longint'(decl_reg)) : 64'(longint'(decl_reg));
        q = ((mag << 32) + 64'd18000) / 64'd36000;
        dec_units = (decl_reg < 0) ? (32'd0 - q[31:0]) : q[31:0];
        bearing = ang - dec_units;
        scaled = 64'(bearing) * 64'd360;
        return scaled[40:32];
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        case ($urandom_range(0, 5))
            0, 1: begin
                s.x = 16'($urandom);
                s.y = 16'($urandom);
            end
            2: begin
                s.x = 16'(int'($urandom_range(0, 512)) - 256);
                s.y = 16'(int'($urandom_range(0, 512)) - 256);
            end
            3: begin
                s.x = 16'($urandom);
                s.y = '0;
            end
            4: begin
                s.x = 16'($urandom);
                s.y = 16'(int'($urandom_range(0, 6)) - 3);
            end
            default: begin
                s.x = CORNERS[$urandom_range(0, 3)];
                s.y = CORNERS[$urandom_range(0, 3)];
            end
        endcase
        return s;
    endfunction

    task automatic push_sample(input int x, input int y);
        sample_t s;
        s.x = 16'(x);
        s.y = 16'(y);
        pending.push_back(s);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_X_GAIN:      gain_reg = val[GAIN_W-1:0];
            REG_X_OFFSET:    offset_reg = val;
            REG_DECLINATION: decl_reg = val;
            default:         ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || heading_q.size() != 0 || start)
            @(posedge clk);
    endtask

    // Driver: bursts of back-to-back transactions separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                heading_q.push_back(heading_of(mag_x_raw, mag_y_raw));
                sent++;
            end
            if (!(start && busy)) begin
                if (gap_left > 0 || pending.size() == 0) begin
                    start <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end else begin
                    cur = pending.pop_front();
                    start <= 1'b1;
                    mag_x_raw <= cur.x;
                    mag_y_raw <= cur.y;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 20);
                        gap_left = $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (heading_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got azimuth %0d",
                         $time, azimuth_deg);
                errors++;
            end else begin
                want = heading_q.pop_front();
                checked++;
                if (azimuth_deg !== want) begin
                    $display("%0t: azimuth mismatch, expected %0d, got %0d",
                             $time, want, azimuth_deg);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            case (p)
                0: begin
                    // Reset calibration; directed corners, Y-zero cases and X wrap.
                    push_sample(0, 0);
                    push_sample(0, 1);
                    push_sample(0, -1);
                    push_sample(1000, 0);
                    push_sample(999, 0);
                    push_sample(1001, 0);
                    push_sample(-32768, 0);
                    push_sample(32767, 0);
                    push_sample(32767, 32767);
                    push_sample(-32768, -32768);
                    push_sample(32767, -32768);
                    push_sample(-32768, 32767);
                    push_sample(0, 32767);
                    push_sample(0, -32768);
                    push_sample(1000, 100);
                    push_sample(1000, -100);
                    push_sample(1001, -1);
                    push_sample(999, -1);
                    push_sample(20000, 5);
                    push_sample(-20000, 5);
                    push_sample(16383, 1);
                    push_sample(-1, -1);
                end
                1: begin
                    write_reg(REG_X_GAIN, 16'h0001);
                    write_reg(REG_X_OFFSET, 16'h0000);
                    write_reg(REG_DECLINATION, 16'h0000);
                end
                2: begin
                    write_reg(REG_X_GAIN, {8'($urandom), 8'h80});
                    write_reg(REG_X_OFFSET, 16'h8000);
                    write_reg(REG_DECLINATION, 16'(-18000));
                end
                3: begin
                    write_reg(REG_X_GAIN, 16'h007F);
                    write_reg(REG_X_OFFSET, 16'h7FFF);
                    write_reg(REG_DECLINATION, 16'(18000));
                end
                4: begin
                    write_reg(REG_X_GAIN, 16'h0000);
                    write_reg(REG_X_OFFSET, 16'($urandom));
                    write_reg(REG_DECLINATION, 16'h7FFF);
                    write_reg(REG_UNUSED, 16'($urandom));
                end
                5: begin
                    write_reg(REG_X_GAIN, 16'h00FF);
                    write_reg(REG_X_OFFSET, 16'h0000);
                    write_reg(REG_DECLINATION, 16'h8000);
                end
                default: begin
                    write_reg(REG_X_GAIN, 16'($urandom));
                    write_reg(REG_X_OFFSET, 16'($urandom));
                    write_reg(REG_DECLINATION, 16'($urandom));
                end
            endcase
            for (int n = 0; n < RANDOM_PER_SETTING; n++)
                pending.push_back(random_sample());
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (heading_q.size() != 0) begin
            $display("%0t: %0d expected headings never arrived", $time, heading_q.size());
            errors++;
        end
        $display("tb: %0d sample pairs sent, %0d headings compared across %0d calibration setups",
                 sent, checked, NUM_SETTINGS);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/chfm_pkg.sv
rtl/chfm_cordic.sv
rtl/compass_heading_from_magnetometer.sv
sim/tb.sv
